// ===== src/sfpd_pkg.sv =====
// Package for the framed packet deframer with Fletcher-8 checksum.
// Holds the configuration and event record types and the shared constants.
// No dependencies.
package sfpd_pkg;

   // Widths of the channel fields.
   localparam int unsigned BYTE_BITS      = 8;
   localparam int unsigned KIND_BITS      = 2;
   localparam int unsigned ERR_OUT_BITS   = 32;
   localparam int unsigned CSR_INDEX_BITS = 8;
   localparam int unsigned RSP_DATA_BITS  = 72;

   // Depth of the event queue between the parser and the output stage.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYNC_FIRST        = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYNC_SECOND       = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WANTED_DESCRIPTOR = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WANTED_LENGTH     = 8'd3;

   localparam logic [BYTE_BITS-1:0] WANTED_LENGTH_RESET = 8'd55;

   // Event kinds carried on the response channel.
   typedef enum logic [KIND_BITS-1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_BAD      = 2'd2
   } kind_type;

   // Current configuration register values.
   typedef struct packed {
      logic [BYTE_BITS-1:0] sync_first;
      logic [BYTE_BITS-1:0] sync_second;
      logic [BYTE_BITS-1:0] wanted_descriptor;
      logic [BYTE_BITS-1:0] wanted_length;
   } cfg_type;

   // One event produced by the parser.
   typedef struct packed {
      kind_type                event_kind;
      logic [BYTE_BITS-1:0]    data_byte;
      logic [BYTE_BITS-1:0]    byte_index;
      logic [BYTE_BITS-1:0]    frame_descriptor;
      logic [BYTE_BITS-1:0]    frame_length;
      logic                    is_wanted_frame;
      logic [ERR_OUT_BITS-1:0] error_count;
   } event_type;

   // Handshake between the parser and the event queue.
   typedef struct packed {
      logic      push;
      event_type entry;
   } push_type;

endpackage

// ===== src/sfpd_front.sv =====
// Front part of the deframer: accepts received bytes, tracks the frame
// phase, runs the Fletcher-8 sums and produces payload and frame events.
// Depends on sfpd_pkg.
module sfpd_front #(
   parameter int unsigned ERROR_COUNT_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            byte_valid,
   input  logic [sfpd_pkg::BYTE_BITS-1:0]  byte_data,
   input  logic                            queue_full,
   output logic                            byte_ready,
   input  sfpd_pkg::cfg_type               cfg,
   output sfpd_pkg::push_type              push_out
);

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_DESC  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHK1  = 3'd5,
      PH_CHK2  = 3'd6
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [sfpd_pkg::BYTE_BITS-1:0]   desc_ff, desc_in;
   logic [sfpd_pkg::BYTE_BITS-1:0]   len_ff, len_in;
   logic [sfpd_pkg::BYTE_BITS-1:0]   pos_ff, pos_in;
   logic [sfpd_pkg::BYTE_BITS-1:0]   sum_low_ff, sum_low_in;
   logic [sfpd_pkg::BYTE_BITS-1:0]   sum_high_ff, sum_high_in;
   logic [sfpd_pkg::BYTE_BITS-1:0]   chk_ff, chk_in;
   logic [ERROR_COUNT_BITS-1:0]      reject_ff, reject_in;

   logic                             fire;
   logic [sfpd_pkg::BYTE_BITS-1:0]   add_low;
   logic [sfpd_pkg::BYTE_BITS-1:0]   add_high;
   logic [sfpd_pkg::BYTE_BITS-1:0]   pos_next;
   logic                             good;
   logic [ERROR_COUNT_BITS+sfpd_pkg::ERR_OUT_BITS-1:0] reject_ext;

   // A byte is taken whenever the queue has room for a possible event.
   assign byte_ready = !queue_full;
   assign fire       = byte_valid && byte_ready;

   // Running Fletcher-8 step and checksum compare.
   assign add_low  = sum_low_ff + byte_data;
   assign add_high = sum_high_ff + add_low;
   assign pos_next = pos_ff + 8'd1;
   assign good     = (chk_ff == sum_low_ff) && (byte_data == sum_high_ff);

   // Error count as shown on the event: low bits of the reject counter.
   assign reject_ext = {{sfpd_pkg::ERR_OUT_BITS{1'b0}}, reject_in};

   // Phase and frame state update for the accepted byte.
   always_comb begin
      phase_in    = phase_ff;
      desc_in     = desc_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      sum_low_in  = sum_low_ff;
      sum_high_in = sum_high_ff;
      chk_in      = chk_ff;
      reject_in   = reject_ff;
      push_out.push                   = 1'b0;
      push_out.entry.event_kind       = sfpd_pkg::KIND_PAYLOAD;
      push_out.entry.data_byte        = '0;
      push_out.entry.byte_index       = '0;
      if (fire) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               phase_in = (byte_data == cfg.sync_second) ? PH_DESC : PH_SYNC1;
            end
            PH_DESC: begin
               desc_in     = byte_data;
               sum_low_in  = byte_data;
               sum_high_in = byte_data;
               phase_in    = PH_LEN;
            end
            PH_LEN: begin
               len_in      = byte_data;
               sum_low_in  = add_low;
               sum_high_in = add_high;
               pos_in      = '0;
               phase_in    = (byte_data == '0) ? PH_CHK1 : PH_DATA;
            end
            PH_DATA: begin
               sum_low_in  = add_low;
               sum_high_in = add_high;
               pos_in      = pos_next;
               if (pos_next >= len_ff) begin
                  phase_in = PH_CHK1;
                  pos_in   = '0;
               end
               push_out.push             = 1'b1;
               push_out.entry.event_kind = sfpd_pkg::KIND_PAYLOAD;
               push_out.entry.data_byte  = byte_data;
               push_out.entry.byte_index = pos_ff;
            end
            PH_CHK1: begin
               chk_in   = byte_data;
               phase_in = PH_CHK2;
            end
            PH_CHK2: begin
               phase_in = PH_SYNC1;
               if (!good) begin
                  reject_in = reject_ff + 1'b1;
               end
               push_out.push             = 1'b1;
               push_out.entry.event_kind = good ? sfpd_pkg::KIND_GOOD
                                                : sfpd_pkg::KIND_BAD;
            end
            default: begin
               // Hunt for the first sync byte; the unused code acts the same.
               phase_in = (byte_data == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
      push_out.entry.frame_descriptor = desc_ff;
      push_out.entry.frame_length     = len_ff;
      push_out.entry.is_wanted_frame  = (desc_ff == cfg.wanted_descriptor) &&
                                        (len_ff == cfg.wanted_length);
      push_out.entry.error_count      = reject_ext[sfpd_pkg::ERR_OUT_BITS-1:0];
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC1;
         desc_ff     <= '0;
         len_ff      <= '0;
         pos_ff      <= '0;
         sum_low_ff  <= '0;
         sum_high_ff <= '0;
         chk_ff      <= '0;
         reject_ff   <= '0;
      end else begin
         phase_ff    <= phase_in;
         desc_ff     <= desc_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
         sum_low_ff  <= sum_low_in;
         sum_high_ff <= sum_high_in;
         chk_ff      <= chk_in;
         reject_ff   <= reject_in;
      end
   end

endmodule

// ===== src/sfpd_queue.sv =====
// Short event queue that decouples the parser from the output stage.
// Depends on sfpd_pkg.
module sfpd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  sfpd_pkg::push_type   push_in,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output sfpd_pkg::event_type  head
);

   localparam int unsigned PB = sfpd_pkg::QUEUE_PTR_BITS;

   sfpd_pkg::event_type slot_ff [sfpd_pkg::QUEUE_DEPTH];
   logic [PB-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PB:0]         count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == (PB+1)'(sfpd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push_in.push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

// ===== src/sfpd_back.sv =====
// Back part of the deframer: output register that drains the event queue
// and presents events on the response channel. Depends on sfpd_pkg.
module sfpd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 queue_not_empty,
   input  sfpd_pkg::event_type                  queue_head,
   output logic                                 queue_pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sfpd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic [sfpd_pkg::KIND_BITS-1:0]       rsp_tuser
);

   logic                valid_ff, valid_in;
   sfpd_pkg::event_type event_ff;

   // Load a new event when the register is empty or being taken.
   assign queue_pop = queue_not_empty && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (queue_pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         event_ff <= queue_head;
      end
   end

   // Pack the event onto the channel.
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = event_ff.event_kind;
   assign rsp_tdata  = {7'd0,
                        event_ff.error_count,
                        event_ff.is_wanted_frame,
                        event_ff.frame_length,
                        event_ff.frame_descriptor,
                        event_ff.byte_index,
                        event_ff.data_byte};

endmodule

// ===== src/sync_framed_packet_deframer_fletcher8_unit.sv =====
// Two-sync-byte frame parser with Fletcher-8 checksum.
//
// Request channel (req_): one received serial byte per request in tdata.
// Response channel (rsp_): payload byte events (tuser = 0) as payload bytes
// arrive, and one good (1) or bad (2) frame event after the second check
// byte; tdata carries byte, index, descriptor, length, wanted flag and the
// running count of rejected frames. The consumer discards the payload of a
// bad frame.
// Configuration channel (csr_): index 0 first sync byte, 1 second sync byte,
// 2 wanted descriptor, 3 wanted length; other indexes are ignored. Write
// only while no frame event is outstanding.
// Throughput is one byte per cycle while the queue is not full: the parser
// updates phase and both checksum sums together for each byte. An event
// reaches rsp_ through the queue entry and then the output register.
// A four-entry event queue sits between parser and output register; when
// the receiver stalls the queue fills and req_tready drops only once it is
// full. Reset clears the queue, returns the parser to the sync hunt, zeroes
// the reject count and loads the configuration defaults (wanted length 55).
//
// Depends on sfpd_pkg, sfpd_front, sfpd_queue and sfpd_back.
module sync_framed_packet_deframer_fletcher8_unit #(
   parameter int unsigned ERROR_COUNT_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Request: [7:0] rx_byte
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [7:0]                               req_tdata,
   // Response: [7:0] data_byte, [15:8] byte_index, [23:16] frame_descriptor,
   // [31:24] frame_length, [32] is_wanted_frame, [64:33] error_count
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [sfpd_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // Response: [1:0] event_kind
   output logic [sfpd_pkg::KIND_BITS-1:0]           rsp_tuser,
   // Configuration write channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [sfpd_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [sfpd_pkg::BYTE_BITS-1:0]           csr_wdata
);

   sfpd_pkg::cfg_type   cfg_ff, cfg_in;
   sfpd_pkg::push_type  push;
   sfpd_pkg::event_type head;
   logic                queue_full;
   logic                queue_not_empty;
   logic                queue_pop;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sfpd_pkg::CSR_SYNC_FIRST:        cfg_in.sync_first        = csr_wdata;
            sfpd_pkg::CSR_SYNC_SECOND:       cfg_in.sync_second       = csr_wdata;
            sfpd_pkg::CSR_WANTED_DESCRIPTOR: cfg_in.wanted_descriptor = csr_wdata;
            sfpd_pkg::CSR_WANTED_LENGTH:     cfg_in.wanted_length     = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first        <= '0;
         cfg_ff.sync_second       <= '0;
         cfg_ff.wanted_descriptor <= '0;
         cfg_ff.wanted_length     <= sfpd_pkg::WANTED_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Parser front.
   sfpd_front #(
      .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .queue_full (queue_full),
      .byte_ready (req_tready),
      .cfg        (cfg_ff),
      .push_out   (push)
   );

   // Event queue.
   sfpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   // Output stage.
   sfpd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (head),
      .queue_pop       (queue_pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser)
   );

endmodule

// ===== dv/tb_sync_framed_packet_deframer_fletcher8_unit.sv =====
// Self-checking testbench for the two-sync-byte frame parser with Fletcher-8 checksum.
// It predicts every payload and frame event from the accepted bytes and checks the
// response stream in order. Depends on sfpd_pkg and sync_framed_packet_deframer_fletcher8_unit.
`timescale 1ns / 1ps

module tb_sync_framed_packet_deframer_fletcher8_unit;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned MAX_REPORTS = 10;

   // Parser phases as the predictor tracks them.
   typedef enum logic [2:0] {
      HUNT_FIRST   = 3'd0,
      HUNT_SECOND  = 3'd1,
      GET_DESC     = 3'd2,
      GET_LEN      = 3'd3,
      GET_PAYLOAD  = 3'd4,
      GET_CHECK_LO = 3'd5,
      GET_CHECK_HI = 3'd6
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [7:0]                          req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [sfpd_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [sfpd_pkg::KIND_BITS-1:0]      rsp_tuser;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [sfpd_pkg::CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [sfpd_pkg::BYTE_BITS-1:0]      csr_wdata  = '0;

   sync_framed_packet_deframer_fletcher8_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Bytes waiting to be sent, and events the parser should still produce.
   logic [7:0]          rx_stream[$];
   sfpd_pkg::event_type events_due[$];
   logic [7:0]          frame_body[$];

   int unsigned bytes_queued = 0;
   int unsigned bytes_taken  = 0;
   int unsigned fail_count   = 0;
   int unsigned cycles       = 0;
   int          gap_left     = 0;
   int          stall_left   = 0;
   bit          quiet        = 1'b0;

   // Register values the stimulus generator builds frames for.
   logic [7:0] gen_sync_first;
   logic [7:0] gen_sync_second;
   logic [7:0] gen_wanted_descriptor;
   logic [7:0] gen_wanted_length;

   // Predictor state.
   sfpd_pkg::cfg_type cfg_now;
   phase_type         phase;
   logic [7:0]        held_desc;
   logic [7:0]        held_len;
   logic [7:0]        pos;
   logic [7:0]        sum_lo;
   logic [7:0]        sum_hi;
   logic [7:0]        check_lo;
   logic [31:0]       reject_count;

   function automatic void report_fail(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         report_fail($sformatf("mismatch %s: expected %0h, got %0h", name, want, got));
      end
   endfunction

   // Apply a register write to the predicted configuration.
   function automatic void apply_reg(input logic [7:0] idx, input logic [7:0] val);
      case (idx)
         sfpd_pkg::CSR_SYNC_FIRST:        cfg_now.sync_first        = val;
         sfpd_pkg::CSR_SYNC_SECOND:       cfg_now.sync_second       = val;
         sfpd_pkg::CSR_WANTED_DESCRIPTOR: cfg_now.wanted_descriptor = val;
         sfpd_pkg::CSR_WANTED_LENGTH:     cfg_now.wanted_length     = val;
         default: ;
      endcase
   endfunction

   // Advance the predicted parser by one byte and record any event it produces.
   function automatic void advance_parser(input logic [7:0] b);
      sfpd_pkg::event_type ev;
      bit                  emit_now;
      bit                  good;
      ev = '0;
      emit_now = 1'b0;
      case (phase)
         HUNT_SECOND: phase = (b == cfg_now.sync_second) ? GET_DESC : HUNT_FIRST;
         GET_DESC: begin
            held_desc = b;
            sum_lo = b;
            sum_hi = b;
            phase = GET_LEN;
         end
         GET_LEN: begin
            held_len = b;
            sum_lo = sum_lo + b;
            sum_hi = sum_hi + sum_lo;
            pos = '0;
            phase = (b == 8'd0) ? GET_CHECK_LO : GET_PAYLOAD;
         end
         GET_PAYLOAD: begin
            ev.event_kind = sfpd_pkg::KIND_PAYLOAD;
            ev.data_byte = b;
            ev.byte_index = pos;
            sum_lo = sum_lo + b;
            sum_hi = sum_hi + sum_lo;
            pos = pos + 8'd1;
            if (pos >= held_len) begin
               phase = GET_CHECK_LO;
               pos = '0;
            end
            emit_now = 1'b1;
         end
         GET_CHECK_LO: begin
            check_lo = b;
            phase = GET_CHECK_HI;
         end
         GET_CHECK_HI: begin
            good = (check_lo == sum_lo) && (b == sum_hi);
            if (!good) begin
               reject_count = reject_count + 32'd1;
            end
            ev.event_kind = good ? sfpd_pkg::KIND_GOOD : sfpd_pkg::KIND_BAD;
            phase = HUNT_FIRST;
            emit_now = 1'b1;
         end
         default: phase = (b == cfg_now.sync_first) ? HUNT_SECOND : HUNT_FIRST;
      endcase
      if (emit_now) begin
         ev.frame_descriptor = held_desc;
         ev.frame_length = held_len;
         ev.is_wanted_frame = (held_desc == cfg_now.wanted_descriptor) &&
                              (held_len == cfg_now.wanted_length);
         ev.error_count = reject_count;
         events_due.push_back(ev);
      end
   endfunction

   function automatic void push_rx(input logic [7:0] b);
      rx_stream.push_back(b);
      bytes_queued++;
   endfunction

   // Queue a complete frame around frame_body, optionally with a broken check byte.
   function automatic void queue_frame(input logic [7:0] desc, input bit bad_lo,
                                       input bit bad_hi);
      logic [7:0] len_byte;
      logic [7:0] lo;
      logic [7:0] hi;
      len_byte = 8'(frame_body.size());
      push_rx(gen_sync_first);
      push_rx(gen_sync_second);
      push_rx(desc);
      push_rx(len_byte);
      lo = desc + len_byte;
      hi = desc + lo;
      foreach (frame_body[i]) begin
         push_rx(frame_body[i]);
         lo = lo + frame_body[i];
         hi = hi + lo;
      end
      if (bad_lo) lo = lo ^ 8'(1 << $urandom_range(0, 7));
      if (bad_hi) hi = hi ^ 8'(1 << $urandom_range(0, 7));
      push_rx(lo);
      push_rx(hi);
   endfunction

   // Mostly well-formed frames with random content, plus noise and broken frames.
   function automatic void queue_traffic(input int unsigned n);
      int unsigned start;
      int unsigned pick;
      int unsigned len;
      int unsigned k;
      logic [7:0]  desc;
      start = bytes_queued;
      while (bytes_queued - start < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            frame_body.delete();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0 && gen_wanted_length <= 8'd30) begin
               len = 32'(gen_wanted_length);
            end
            desc = ($urandom_range(0, 2) == 0) ? gen_wanted_descriptor : 8'($urandom);
            repeat (len) frame_body.push_back(8'($urandom));
            k = $urandom_range(0, 7);
            queue_frame(desc, k == 0, k == 1);
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 4)) push_rx(8'($urandom));
         end else if (pick < 91) begin
            // First sync byte followed by anything but the second one.
            push_rx(gen_sync_first);
            push_rx(gen_sync_second ^ 8'($urandom_range(1, 255)));
         end else begin
            // Frame header followed by random bytes that may fall short of its length.
            push_rx(gen_sync_first);
            push_rx(gen_sync_second);
            push_rx(8'($urandom));
            push_rx(8'($urandom_range(1, 12)));
            repeat ($urandom_range(0, 4)) push_rx(8'($urandom));
         end
      end
   endfunction

   // One register write; returns at the edge where it was accepted.
   task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input logic [7:0] s1, input logic [7:0] s2,
                                 input logic [7:0] wd, input logic [7:0] wl,
                                 input logic [7:0] stray_index);
      gen_sync_first = s1;
      gen_sync_second = s2;
      gen_wanted_descriptor = wd;
      gen_wanted_length = wl;
      write_reg(sfpd_pkg::CSR_SYNC_FIRST, s1);
      write_reg(sfpd_pkg::CSR_SYNC_SECOND, s2);
      write_reg(sfpd_pkg::CSR_WANTED_DESCRIPTOR, wd);
      write_reg(sfpd_pkg::CSR_WANTED_LENGTH, wl);
      // Writes to unused indexes must leave the registers alone.
      if (stray_index > sfpd_pkg::CSR_WANTED_LENGTH) begin
         write_reg(stray_index, 8'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued byte is taken and every event has arrived,
   // then let the pipeline settle.
   task automatic wait_idle();
      while (bytes_taken != bytes_queued || events_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Request driver with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (rx_stream.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_left = int'($urandom_range(0, 2));
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= rx_stream.pop_front();
         end
      end
   end

   // Monitor: tracks register writes and requests, checks responses, paces rsp_tready.
   always @(posedge clock) begin
      sfpd_pkg::event_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         cfg_now = '{sync_first: 8'd0, sync_second: 8'd0, wanted_descriptor: 8'd0,
                     wanted_length: sfpd_pkg::WANTED_LENGTH_RESET};
         phase = HUNT_FIRST;
         held_desc = '0;
         held_len = '0;
         pos = '0;
         sum_lo = '0;
         sum_hi = '0;
         check_lo = '0;
         reject_count = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            apply_reg(csr_index, csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            advance_parser(req_tdata);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (events_due.size() == 0) begin
               report_fail($sformatf("unexpected response: kind %0d data %0h",
                                     rsp_tuser, rsp_tdata));
            end else begin
               want = events_due.pop_front();
               check_field("event_kind", 32'(want.event_kind), 32'(rsp_tuser));
               check_field("data_byte", 32'(want.data_byte), 32'(rsp_tdata[7:0]));
               check_field("byte_index", 32'(want.byte_index), 32'(rsp_tdata[15:8]));
               check_field("frame_descriptor", 32'(want.frame_descriptor),
                           32'(rsp_tdata[23:16]));
               check_field("frame_length", 32'(want.frame_length),
                           32'(rsp_tdata[31:24]));
               check_field("is_wanted_frame", 32'(want.is_wanted_frame),
                           32'(rsp_tdata[32]));
               check_field("error_count", want.error_count, rsp_tdata[64:33]);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = int'($urandom_range(0, 2));
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      gen_sync_first = 8'd0;
      gen_sync_second = 8'd0;
      gen_wanted_descriptor = 8'd0;
      gen_wanted_length = sfpd_pkg::WANTED_LENGTH_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: an empty frame made of zero bytes only.
      frame_body.delete();
      queue_frame(8'h00, 1'b0, 1'b0);
      wait_idle();

      // Directed frames: extreme payload values, zero length, bad checks, bad second sync.
      apply_settings(8'hAA, 8'h55, 8'h10, 8'd3, 8'd0);
      frame_body = '{8'h00, 8'hFF, 8'h80};
      queue_frame(8'h10, 1'b0, 1'b0);
      frame_body.delete();
      queue_frame(8'h11, 1'b0, 1'b1);
      push_rx(8'hFF);
      push_rx(8'h55);
      // The second first-sync byte is a failed second sync, not a new start.
      push_rx(8'hAA);
      push_rx(8'hAA);
      push_rx(8'h55);
      frame_body = '{8'h7F};
      queue_frame(8'hFF, 1'b1, 1'b0);
      wait_idle();

      // Random configuration and traffic.
      apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)),
                     8'($urandom_range(4, 255)));
      queue_traffic(60);
      wait_idle();

      // All ones, with one frame of the largest length.
      apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      frame_body.delete();
      repeat (255) frame_body.push_back(8'($urandom));
      queue_frame(8'hFF, 1'b0, 1'b0);
      queue_traffic(60);
      wait_idle();

      // All zeros: equal sync bytes and a wanted length of zero.
      apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'($urandom_range(4, 255)));
      queue_traffic(60);
      wait_idle();

      // Final stretch without idling on either side.
      quiet = 1'b1;
      apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)),
                     8'd0);
      queue_traffic(60);
      wait_idle();
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
